### hdl/shle_pkg.sv
// Shared widths, constants and register indices of the harmonic level extractor.
package shle_pkg;

  localparam int MAX_BINS_DEF      = 4096;
  localparam int NUM_HARMONICS_DEF = 10;

  localparam int LEVEL_W  = 24;
  localparam int BINCFG_W = 13;
  localparam int RADIUS_W = 12;
  localparam int NUM_W    = 4;
  localparam int BIN_W    = 12;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_METHOD      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_BINS = 2'd3;

  localparam logic METHOD_EXACT  = 1'b0;
  localparam logic METHOD_RADIUS = 1'b1;

  localparam logic [BINCFG_W-1:0] UPPER_BIN_RST = 13'd4096;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 24'sh800000;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 24'sh7FFFFF;

  typedef logic signed [LEVEL_W-1:0] level_t;

endpackage

### hdl/shle_if.sv
// Valid/ready channel interfaces for spectrum bins and harmonic results.
interface shle_in_if
  import shle_pkg::*;
();
  logic   valid;
  logic   ready;
  level_t bin_level;
  logic   last_bin;

  modport source (output valid, output bin_level, output last_bin, input ready);
  modport sink   (input valid, input bin_level, input last_bin, output ready);
endinterface

interface shle_out_if
  import shle_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] harmonic_number;
  logic [BIN_W-1:0] bin_index;
  level_t           level;
  logic             empty_res;
  logic             last_result;

  modport source (output valid, output harmonic_number, output bin_index, output level,
                  output empty_res, output last_result, input ready);
  modport sink   (input valid, input harmonic_number, input bin_index, input level,
                  input empty_res, input last_result, output ready);
endinterface

### hdl/shle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module shle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/spectral_harmonic_level_extractor_core.sv
// Top level of the harmonic level extractor: bin loading, peak search and harmonic reports.
//
// Spectrum bins are taken one per cycle into the spectrum memory while the block is loading.
// The item that carries last_bin closes the frame; from then on no bin is taken until the
// last of the NUM_HARMONICS+1 results has been placed in the output register. The analysis
// is paced by the single read port of the spectrum memory: the fundamental search reads each
// bin of the clipped search range, an exact harmonic inside the frame reads its one bin and
// a radius harmonic reads each bin of its clipped window; other harmonics need no read.
// Each result is then placed in the output register, where it is held while the result
// channel stalls. The memory needs no clearing pass, since only bins received in the current
// frame are ever read.
module spectral_harmonic_level_extractor_core
  import shle_pkg::*;
#(
  parameter int MAX_BINS      = MAX_BINS_DEF,
  parameter int NUM_HARMONICS = NUM_HARMONICS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  shle_in_if.sink              in_ch,
  shle_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW  = $clog2(MAX_BINS);
  localparam int NW  = AW + 1;
  localparam int HW  = $clog2(NUM_HARMONICS + 1);
  localparam int PW  = ((AW > RADIUS_W) ? AW : RADIUS_W) + HW + 1;
  localparam int AXW = (AW > BIN_W) ? AW : BIN_W;
  localparam int KXW = (HW > NUM_W) ? HW : NUM_W;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_HSET  = 3'd2;
  localparam logic [2:0] ST_HREAD = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [NW-1:0]       count_r, count_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [BINCFG_W-1:0] lower_r, upper_r;
  logic                method_r;
  logic [RADIUS_W-1:0] radius_r;

  logic [PW-1:0]       addr_r, addr_nxt;
  logic [PW-1:0]       end_r, end_nxt;
  logic                pend_r, pend_nxt;
  logic [PW-1:0]       pidx_r, pidx_nxt;
  logic                any_r, any_nxt;
  level_t              best_r, best_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  logic                scan_peak_r, scan_peak_nxt;

  logic                peak_found_r, peak_found_nxt;
  logic [AW-1:0]       peak_bin_r, peak_bin_nxt;
  level_t              peak_level_r, peak_level_nxt;

  logic [HW-1:0]       k_r, k_nxt;
  logic [PW-1:0]       c_r, c_nxt;
  logic [PW-1:0]       b_r, b_nxt;

  logic [BIN_W-1:0]    res_bin_r, res_bin_nxt;
  level_t              res_level_r, res_level_nxt;
  logic                res_empty_r, res_empty_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]    out_num_r, out_num_nxt;
  logic [BIN_W-1:0]    out_bin_r, out_bin_nxt;
  level_t              out_level_r, out_level_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_last_r, out_last_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [LEVEL_W-1:0]  ram_rdata;
  level_t              rd_level;

  logic                in_acc;
  logic                issue;
  level_t              sub_a;
  logic signed [LEVEL_W:0] diff;
  level_t              diff_sat;
  logic [PW-1:0]       n_ext;
  logic [PW-1:0]       upper_ext;
  logic [PW-1:0]       win_top;
  logic [AXW-1:0]      best_idx_ext, peak_bin_ext;
  logic [KXW-1:0]      k_ext;
  logic [NW-1:0]       count_inc;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign ram_we    = in_acc && (count_r < NW'(MAX_BINS));
  assign rd_level  = level_t'(ram_rdata);
  assign n_ext     = PW'(n_r);
  assign upper_ext = PW'(upper_r);
  assign win_top   = c_r + b_r;
  assign issue     = addr_r < end_r;
  assign best_idx_ext = AXW'(best_idx_r);
  assign peak_bin_ext = AXW'(peak_bin_r);
  assign k_ext     = KXW'(k_r);
  assign count_inc = ram_we ? count_r + NW'(1) : count_r;

  // One shared saturating subtractor: harmonic level minus fundamental level.
  assign sub_a = (state_r == ST_HREAD) ? rd_level : best_r;
  assign diff  = {sub_a[LEVEL_W-1], sub_a} - {peak_level_r[LEVEL_W-1], peak_level_r};
  always_comb begin
    if (diff[LEVEL_W] != diff[LEVEL_W-1]) begin
      diff_sat = diff[LEVEL_W] ? LEVEL_MIN : LEVEL_MAX;
    end else begin
      diff_sat = diff[LEVEL_W-1:0];
    end
  end

  shle_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (MAX_BINS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_ch.bin_level),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    addr_nxt       = addr_r;
    end_nxt        = end_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = addr_r;
    any_nxt        = any_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    scan_peak_nxt  = scan_peak_r;
    peak_found_nxt = peak_found_r;
    peak_bin_nxt   = peak_bin_r;
    peak_level_nxt = peak_level_r;
    k_nxt          = k_r;
    c_nxt          = c_r;
    b_nxt          = b_r;
    res_bin_nxt    = res_bin_r;
    res_level_nxt  = res_level_r;
    res_empty_nxt  = res_empty_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_num_nxt    = out_num_r;
    out_bin_nxt    = out_bin_r;
    out_level_nxt  = out_level_r;
    out_empty_nxt  = out_empty_r;
    out_last_nxt   = out_last_r;
    ram_raddr      = addr_r[AW-1:0];

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          count_nxt = count_inc;
          if (in_ch.last_bin) begin
            count_nxt     = '0;
            n_nxt         = count_inc;
            addr_nxt      = PW'(lower_r);
            end_nxt       = (upper_ext < PW'(count_inc)) ? upper_ext : PW'(count_inc);
            any_nxt       = 1'b0;
            scan_peak_nxt = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Reads are issued one a cycle; each compare happens when its data returns.
        if (issue) begin
          addr_nxt = addr_r + PW'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && (!any_r || (rd_level > best_r))) begin
          any_nxt      = 1'b1;
          best_nxt     = rd_level;
          best_idx_nxt = pidx_r[AW-1:0];
        end
        if (!issue && !pend_r) begin
          state_nxt = ST_EMIT;
          if (scan_peak_r) begin
            peak_found_nxt = any_r;
            peak_bin_nxt   = any_r ? best_idx_r : '0;
            peak_level_nxt = any_r ? best_r : LEVEL_MIN;
            k_nxt          = '0;
            c_nxt          = '0;
            b_nxt          = '0;
            res_bin_nxt    = any_r ? best_idx_ext[BIN_W-1:0] : '0;
            res_level_nxt  = any_r ? best_r : '0;
            res_empty_nxt  = !any_r;
          end else begin
            res_bin_nxt   = (c_r < n_ext) ? c_r[BIN_W-1:0] : '0;
            res_level_nxt = any_r ? diff_sat : LEVEL_MIN;
            res_empty_nxt = !any_r;
          end
        end
      end

      ST_HSET: begin
        state_nxt = ST_EMIT;
        if (!peak_found_r) begin
          res_bin_nxt   = '0;
          res_level_nxt = LEVEL_MIN;
          res_empty_nxt = 1'b1;
        end else if (method_r == METHOD_EXACT) begin
          if (c_r < n_ext) begin
            ram_raddr = c_r[AW-1:0];
            state_nxt = ST_HREAD;
          end else begin
            res_bin_nxt   = '0;
            res_level_nxt = LEVEL_MIN;
            res_empty_nxt = 1'b1;
          end
        end else if (k_r == HW'(1)) begin
          res_bin_nxt   = peak_bin_ext[BIN_W-1:0];
          res_level_nxt = '0;
          res_empty_nxt = 1'b0;
        end else begin
          // Window around the harmonic position, clipped to the frame.
          addr_nxt      = (c_r >= b_r) ? c_r - b_r : '0;
          end_nxt       = (win_top > n_ext) ? n_ext : win_top;
          any_nxt       = 1'b0;
          scan_peak_nxt = 1'b0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_HREAD: begin
        res_bin_nxt   = c_r[BIN_W-1:0];
        res_level_nxt = diff_sat;
        res_empty_nxt = 1'b0;
        state_nxt     = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_num_nxt   = k_ext[NUM_W-1:0];
          out_bin_nxt   = res_bin_r;
          out_level_nxt = res_level_r;
          out_empty_nxt = res_empty_r;
          out_last_nxt  = (k_r == HW'(NUM_HARMONICS));
          if (k_r == HW'(NUM_HARMONICS)) begin
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + HW'(1);
            c_nxt     = c_r + PW'(peak_bin_r);
            b_nxt     = (k_r == '0) ? '0 : b_r + PW'(radius_r);
            state_nxt = ST_HSET;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      n_r          <= '0;
      pend_r       <= 1'b0;
      any_r        <= 1'b0;
      scan_peak_r  <= 1'b0;
      peak_found_r <= 1'b0;
      peak_bin_r   <= '0;
      peak_level_r <= LEVEL_MIN;
      k_r          <= '0;
      out_valid_r  <= 1'b0;
      lower_r      <= '0;
      upper_r      <= UPPER_BIN_RST;
      method_r     <= METHOD_EXACT;
      radius_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      n_r          <= n_nxt;
      pend_r       <= pend_nxt;
      any_r        <= any_nxt;
      scan_peak_r  <= scan_peak_nxt;
      peak_found_r <= peak_found_nxt;
      peak_bin_r   <= peak_bin_nxt;
      peak_level_r <= peak_level_nxt;
      k_r          <= k_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_LOWER_BIN:   lower_r  <= cfg_data[BINCFG_W-1:0];
          REG_UPPER_BIN:   upper_r  <= cfg_data[BINCFG_W-1:0];
          REG_METHOD:      method_r <= cfg_data[0];
          REG_RADIUS_BINS: radius_r <= cfg_data[RADIUS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    end_r       <= end_nxt;
    pidx_r      <= pidx_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    c_r         <= c_nxt;
    b_r         <= b_nxt;
    res_bin_r   <= res_bin_nxt;
    res_level_r <= res_level_nxt;
    res_empty_r <= res_empty_nxt;
    out_num_r   <= out_num_nxt;
    out_bin_r   <= out_bin_nxt;
    out_level_r <= out_level_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready            = (state_r == ST_LOAD);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.harmonic_number = out_num_r;
  assign out_ch.bin_index       = out_bin_r;
  assign out_ch.level           = out_level_r;
  assign out_ch.empty_res       = out_empty_r;
  assign out_ch.last_result     = out_last_r;

endmodule

### hdl/shle_checker.sv
// Port-level assertions for the harmonic level extractor, bound to its top level.
module shle_checker
  import shle_pkg::*;
#(
  parameter int NUM_HARMONICS = NUM_HARMONICS_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [NUM_W-1:0] out_num,
  input logic [BIN_W-1:0] out_bin,
  input level_t           out_level,
  input logic             out_empty,
  input logic             out_last
);

  localparam logic [NUM_W-1:0] LAST_NUM = NUM_W'(NUM_HARMONICS);

  // A stalled result must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_num) && $stable(out_bin) &&
    $stable(out_level) && $stable(out_empty) && $stable(out_last))
    else $error("result changed while stalled");

  // No bin may be taken while a run is still being reported.
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("bin accepted during analysis");

  a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_num == LAST_NUM)
    else $error("closing result carries wrong harmonic number");

  // An empty result other than the fundamental always reports the floor level.
  a_empty_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty && out_num != '0 |-> out_level == LEVEL_MIN)
    else $error("empty harmonic with non-floor level");

endmodule

bind spectral_harmonic_level_extractor_core shle_checker #(
  .NUM_HARMONICS (NUM_HARMONICS)
) u_shle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_num   (out_ch.harmonic_number),
  .out_bin   (out_ch.bin_index),
  .out_level (out_ch.level),
  .out_empty (out_ch.empty_res),
  .out_last  (out_ch.last_result)
);

### test/tb_top.sv
// Self-checking testbench for the harmonic level extractor core.
`timescale 1ns / 100ps

module tb_top
  import shle_pkg::*;
();

  localparam int     LIMIT_CYCLES = 1000000;
  localparam longint LVL_FLOOR    = LEVEL_MIN;
  localparam longint LVL_CEIL     = LEVEL_MAX;

  typedef struct packed {
    logic             last;
    level_t           lvl;
  } bin_item_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [BIN_W-1:0] bin;
    level_t           level;
    logic             empty;
    logic             last;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOWER_BIN;
  logic [CFG_W-1:0]     cfg_data = '0;

  shle_in_if  in_ch ();
  shle_out_if out_ch ();

  spectral_harmonic_level_extractor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the stored frame and a copy of the registers.
  level_t            spec_mem [MAX_BINS_DEF];
  int                frame_len;
  logic [BINCFG_W-1:0] reg_lower;
  logic [BINCFG_W-1:0] reg_upper;
  logic              reg_method;
  logic [RADIUS_W-1:0] reg_radius;

  bin_item_t pending_bins[$];
  report_t   expected_reports[$];
  bin_item_t next_bin;
  report_t   want;
  int        bins_queued = 0;
  int        bins_taken = 0;
  int        results_seen = 0;
  int        mismatch_count = 0;
  int        idle_pct = 36;
  int        cycle_count = 0;
  int        random_bins = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch: %s", what);
  endtask

  function automatic longint clamp_level(input longint v);
    if (v > LVL_CEIL) return LVL_CEIL;
    if (v < LVL_FLOOR) return LVL_FLOOR;
    return v;
  endfunction

  function automatic void push_report(input int k, input longint bin, input longint lvl,
                                      input bit empty);
    report_t r;
    r.num   = NUM_W'(k);
    r.bin   = BIN_W'(bin);
    r.level = level_t'(lvl);
    r.empty = empty;
    r.last  = (k == NUM_HARMONICS_DEF);
    expected_reports.push_back(r);
  endfunction

  // Stores one bin; a closing bin runs the peak search and the harmonic reports.
  function automatic void harmonic_predict(input level_t lvl, input logic last);
    int     n, hi, i, k, pk;
    longint c, span, lo, top, j, best, pos, at, pk_lvl;
    bit     found, any;
    if (frame_len < MAX_BINS_DEF) begin
      spec_mem[frame_len] = lvl;
      frame_len++;
    end
    if (!last) return;
    n = frame_len;
    frame_len = 0;
    found = 1'b0;
    pk = 0;
    pk_lvl = LVL_FLOOR;
    hi = (int'(reg_upper) < n) ? int'(reg_upper) : n;
    for (i = int'(reg_lower); i < hi; i++) begin
      if (!found || longint'(spec_mem[i]) > pk_lvl) begin
        found = 1'b1;
        pk = i;
        pk_lvl = spec_mem[i];
      end
    end
    if (!found) begin
      push_report(0, 0, 0, 1'b1);
      for (k = 1; k <= NUM_HARMONICS_DEF; k++) push_report(k, 0, LVL_FLOOR, 1'b1);
      return;
    end
    push_report(0, pk, pk_lvl, 1'b0);
    for (k = 1; k <= NUM_HARMONICS_DEF; k++) begin
      if (reg_method == METHOD_EXACT) begin
        pos = longint'(pk) * k;
        if (pos < n) push_report(k, pos, clamp_level(longint'(spec_mem[pos]) - pk_lvl), 1'b0);
        else push_report(k, 0, LVL_FLOOR, 1'b1);
      end else if (k == 1) begin
        push_report(1, pk, 0, 1'b0);
      end else begin
        c = longint'(pk) * k;
        span = longint'(k - 1) * longint'(reg_radius);
        lo = c - span;
        top = c + span;
        at = (c < n) ? c : 0;
        if (lo < 0) lo = 0;
        if (top > n) top = n;
        any = 1'b0;
        best = LVL_FLOOR;
        for (j = lo; j < top; j++) begin
          if (!any || longint'(spec_mem[j]) > best) begin
            any = 1'b1;
            best = spec_mem[j];
          end
        end
        if (any) push_report(k, at, clamp_level(best - pk_lvl), 1'b0);
        else push_report(k, at, LVL_FLOOR, 1'b1);
      end
    end
  endfunction

  function automatic level_t pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return level_t'($urandom());
    if (r < 7) return level_t'(int'($urandom_range(0, 4000)) - 2000);
    if (r == 7) return ($urandom_range(0, 1) != 0) ? LEVEL_MAX : LEVEL_MIN;
    // A handful of coarse values makes equal levels, and so ties, common.
    return level_t'(256 * int'($urandom_range(0, 2)));
  endfunction

  task automatic queue_bin(input level_t lvl, input logic last);
    bin_item_t b;
    b.lvl = lvl;
    b.last = last;
    pending_bins.push_back(b);
    bins_queued++;
  endtask

  task automatic queue_levels(input level_t vals[$]);
    foreach (vals[i]) queue_bin(vals[i], i == vals.size() - 1);
  endtask

  task automatic queue_random_frame(input int len);
    for (int i = 0; i < len; i++) queue_bin(pick_level(), i == len - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    case (idx)
      REG_LOWER_BIN: reg_lower = BINCFG_W'(val);
      REG_UPPER_BIN: reg_upper = BINCFG_W'(val);
      REG_METHOD:    reg_method = 1'(val);
      default:       reg_radius = RADIUS_W'(val);
    endcase
  endtask

  task automatic set_regs(input int lo, input int up, input logic meth, input int rad);
    write_reg(REG_LOWER_BIN, lo);
    write_reg(REG_UPPER_BIN, up);
    write_reg(REG_METHOD, int'(meth));
    write_reg(REG_RADIUS_BINS, rad);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued bin is taken and every expected report has come back.
  task automatic settle();
    do @(posedge clk);
    while (bins_taken != bins_queued || expected_reports.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Bin driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        harmonic_predict(in_ch.bin_level, in_ch.last_bin);
        bins_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bins.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_bin = pending_bins.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.bin_level <= next_bin.lvl;
          in_ch.last_bin <= next_bin.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_reports.pop_front();
        if (out_ch.harmonic_number !== want.num)
          report_mismatch($sformatf("result %0d harmonic_number %0d, wanted %0d",
                                    results_seen, out_ch.harmonic_number, want.num));
        if (out_ch.bin_index !== want.bin)
          report_mismatch($sformatf("result %0d bin_index %0d, wanted %0d",
                                    results_seen, out_ch.bin_index, want.bin));
        if (out_ch.level !== want.level)
          report_mismatch($sformatf("result %0d level %0d, wanted %0d",
                                    results_seen, out_ch.level, want.level));
        if (out_ch.empty_res !== want.empty)
          report_mismatch($sformatf("result %0d empty_res %0b, wanted %0b",
                                    results_seen, out_ch.empty_res, want.empty));
        if (out_ch.last_result !== want.last)
          report_mismatch($sformatf("result %0d last_result %0b, wanted %0b",
                                    results_seen, out_ch.last_result, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int lo, up, rad, phase, r;
    in_ch.valid = 1'b0;
    in_ch.bin_level = '0;
    in_ch.last_bin = 1'b0;
    out_ch.ready = 1'b0;
    frame_len = 0;
    reg_lower = '0;
    reg_upper = UPPER_BIN_RST;
    reg_method = METHOD_EXACT;
    reg_radius = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: ties keep the lower bin, negative saturation, peak at bin zero.
    queue_levels('{-100, LEVEL_MAX, 0, LEVEL_MAX, LEVEL_MIN, 5});
    queue_levels('{7, -3});
    // A peak at the floor with a full-scale harmonic outside the search range.
    settle();
    set_regs(1, 2, METHOD_EXACT, 0);
    queue_levels('{LEVEL_MAX, LEVEL_MIN, LEVEL_MAX});
    // Search ranges that hold no received bin.
    settle();
    set_regs(4096, 4096, METHOD_EXACT, 0);
    queue_levels('{1, 2});
    settle();
    set_regs(0, 0, METHOD_RADIUS, 0);
    queue_levels('{3});
    // Radius mode with empty windows, then with windows clipped at both ends.
    settle();
    set_regs(0, 4096, METHOD_RADIUS, 0);
    queue_levels('{0, 50, 20, 30, -40});
    settle();
    set_regs(3, 4096, METHOD_RADIUS, 4095);
    queue_levels('{-7, 3, 9, LEVEL_MIN, 1, 2});

    phase = 0;
    while (random_bins < 350) begin
      settle();
      idle_pct = (phase == 2 || phase == 3) ? 0 : 36;
      r = $urandom_range(0, 9);
      if (r < 6) lo = $urandom_range(0, 4);
      else if (r < 8) lo = $urandom_range(0, 40);
      else if (r == 8) lo = 4096;
      else lo = $urandom_range(0, 4096);
      r = $urandom_range(0, 9);
      if (r < 5) up = 4096;
      else if (r < 8) up = (lo + 30 > 4096) ? 4096 : lo + int'($urandom_range(0, 30));
      else if (r == 8) up = 0;
      else up = $urandom_range(0, 4096);
      r = $urandom_range(0, 9);
      if (r < 5) rad = $urandom_range(0, 3);
      else if (r < 8) rad = $urandom_range(4, 12);
      else if (r == 8) rad = 4095;
      else rad = $urandom_range(0, 4095);
      set_regs(lo, up, logic'($urandom_range(0, 1)), rad);
      repeat ($urandom_range(2, 5)) begin
        r = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 40) : $urandom_range(41, 120);
        queue_random_frame(r);
        random_bins += r;
      end
      phase++;
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
